// File: rtl/ccug_pkg.sv
package ccug_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int AMP_BITS   = 16;

  // Fixed field widths
  localparam int MODE_BITS = 2;
  localparam int QSEL_BITS = 4;
  localparam int STAT_BITS = 2;
  localparam int NQ_BITS   = QSEL_BITS + 1;

  localparam int IDX_BITS       = MAX_QUBITS;
  localparam int PAIR_BITS      = MAX_QUBITS - 1;
  localparam int BANK_ADDR_BITS = MAX_QUBITS - 1;
  localparam int ENTRY_BITS     = 2 * AMP_BITS;

  localparam int FRAC      = AMP_BITS - 1;
  localparam int PROD_BITS = 2 * AMP_BITS;
  localparam int RND_BITS  = AMP_BITS + 1;
  localparam int SUM_BITS  = RND_BITS + 2;

  localparam logic [PROD_BITS:0] RND_HALF = (PROD_BITS + 1)'(longint'(1) <<< (FRAC - 1));
  localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((longint'(1) <<< FRAC) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO = SUM_BITS'(-(longint'(1) <<< FRAC));

  localparam logic [MODE_BITS-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_READ = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_GATE = 2'd2;

  localparam logic [STAT_BITS-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_BAD_QUBIT = 2'd2;

  localparam logic [QSEL_BITS-1:0] QUBITS_RESET = 4'd10;

  // Pair travelling down the butterfly pipeline
  typedef struct packed {
    logic                      valid;
    logic                      we;
    logic                      up_bank;
    logic [BANK_ADDR_BITS-1:0] up_addr;
    logic [BANK_ADDR_BITS-1:0] lo_addr;
  } tag_t;

  // Q2.2F product to Q2.F, nearest with ties up
  function automatic logic signed [RND_BITS-1:0] rnd(input logic signed [PROD_BITS-1:0] p);
    logic [PROD_BITS:0] x;
    x = {p[PROD_BITS-1], p} + RND_HALF;
    return x[FRAC +: RND_BITS];
  endfunction

  function automatic logic signed [AMP_BITS-1:0] sat(input logic signed [SUM_BITS-1:0] v);
    logic signed [AMP_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[AMP_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[AMP_BITS-1:0];
    end else begin
      r = v[AMP_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/controlled_compact_unitary_gate.sv
// One item at a time; the next is taken once the result is registered. A gate sweeps
// one amplitude pair per cycle through the two parity banks (one read and one write
// port each) and the butterfly pipeline.
// Reset (rst, synchronous) idles the block and sets qubits_in_use to 10; the store is not cleared.
module controlled_compact_unitary_gate
  import ccug_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [QSEL_BITS-1:0]        cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [MODE_BITS-1:0]        mode,
  input  logic [IDX_BITS-1:0]         amp_index,
  input  logic signed [AMP_BITS-1:0]  load_re,
  input  logic signed [AMP_BITS-1:0]  load_im,
  input  logic [QSEL_BITS-1:0]        target_qubit,
  input  logic [QSEL_BITS-1:0]        control_qubit,
  input  logic                        control_used,
  input  logic signed [AMP_BITS-1:0]  alpha_re,
  input  logic signed [AMP_BITS-1:0]  alpha_im,
  input  logic signed [AMP_BITS-1:0]  beta_re,
  input  logic signed [AMP_BITS-1:0]  beta_im,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [AMP_BITS-1:0]  read_re,
  output logic signed [AMP_BITS-1:0]  read_im,
  output logic [STAT_BITS-1:0]        status
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_RDWAIT = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [QSEL_BITS-1:0] qubits_in_use;
  logic [NQ_BITS-1:0]   n_eff;

  // Latched item
  logic [MODE_BITS-1:0]       item_mode;
  logic [IDX_BITS-1:0]        item_idx;
  logic signed [AMP_BITS-1:0] item_load_re, item_load_im;
  logic [QSEL_BITS-1:0]       item_tq, item_cq;
  logic                       item_cuse;
  logic signed [AMP_BITS-1:0] item_ar, item_ai, item_br, item_bi;

  logic                       idx_bad, qubit_bad;
  logic                       idx_bank;
  logic [BANK_ADDR_BITS-1:0]  idx_addr;

  logic [PAIR_BITS-1:0]       pair_cnt, pair_last;
  logic [IDX_BITS-1:0]        half_m1, low_mask, tq_bit, pair_ext, up_idx, lo_idx, ctrl_vec;
  logic                       pair_done;
  tag_t                       issue_tag, s1_tag, s2_tag;

  logic                       ram_we [2];
  logic [BANK_ADDR_BITS-1:0]  ram_waddr [2];
  logic [ENTRY_BITS-1:0]      ram_wdata [2];
  logic [BANK_ADDR_BITS-1:0]  ram_raddr [2];
  logic [ENTRY_BITS-1:0]      ram_rdata [2];

  logic [ENTRY_BITS-1:0]      up_word, lo_word, idx_word;
  logic signed [AMP_BITS-1:0] new_up_re, new_up_im, new_lo_re, new_lo_im;

  logic signed [AMP_BITS-1:0] res_re, res_im;
  logic [STAT_BITS-1:0]       res_status;
  logic                       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      qubits_in_use <= QUBITS_RESET;
    end else if (cfg_write) begin
      qubits_in_use <= cfg_data;
    end
  end

  // Clamp the qubit count into 1 .. MAX_QUBITS
  always_comb begin
    if (qubits_in_use == '0) begin
      n_eff = NQ_BITS'(1);
    end else if ({1'b0, qubits_in_use} > NQ_BITS'(MAX_QUBITS)) begin
      n_eff = NQ_BITS'(MAX_QUBITS);
    end else begin
      n_eff = {1'b0, qubits_in_use};
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_mode    <= mode;
      item_idx     <= amp_index;
      item_load_re <= load_re;
      item_load_im <= load_im;
      item_tq      <= target_qubit;
      item_cq      <= control_qubit;
      item_cuse    <= control_used;
      item_ar      <= alpha_re;
      item_ai      <= alpha_im;
      item_br      <= beta_re;
      item_bi      <= beta_im;
    end
  end

  assign idx_bad   = ((item_idx >> n_eff) != '0);
  assign qubit_bad = ({1'b0, item_tq} >= n_eff)
                  || (item_cuse && (({1'b0, item_cq} >= n_eff) || (item_cq == item_tq)));
  assign idx_bank  = ^item_idx;
  assign idx_addr  = item_idx[IDX_BITS-1:1];

  // Pair walk: insert a zero at the target bit of the pair count
  assign half_m1   = (IDX_BITS'(1) << (n_eff - NQ_BITS'(1))) - IDX_BITS'(1);
  assign pair_last = half_m1[PAIR_BITS-1:0];
  assign pair_done = (pair_cnt == pair_last);
  assign tq_bit    = IDX_BITS'(1) << item_tq;
  assign low_mask  = tq_bit - IDX_BITS'(1);
  assign pair_ext  = {1'b0, pair_cnt};
  assign up_idx    = ((pair_ext & ~low_mask) << 1) | (pair_ext & low_mask);
  assign lo_idx    = up_idx | tq_bit;
  assign ctrl_vec  = up_idx >> item_cq;

  always_comb begin
    issue_tag.valid   = (state == S_SWEEP);
    issue_tag.we      = !item_cuse || ctrl_vec[0];
    issue_tag.up_bank = ^up_idx;
    issue_tag.up_addr = up_idx[IDX_BITS-1:1];
    issue_tag.lo_addr = lo_idx[IDX_BITS-1:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else begin
      s1_tag <= issue_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      pair_cnt <= '0;
    end else if (state == S_SWEEP) begin
      pair_cnt <= pair_cnt + PAIR_BITS'(1);
    end
  end

  // Read addresses: up and lo always sit in opposite parity banks
  always_comb begin
    if (state == S_SWEEP) begin
      ram_raddr[0] = issue_tag.up_bank ? issue_tag.lo_addr : issue_tag.up_addr;
      ram_raddr[1] = issue_tag.up_bank ? issue_tag.up_addr : issue_tag.lo_addr;
    end else begin
      ram_raddr[0] = idx_addr;
      ram_raddr[1] = idx_addr;
    end
  end

  // Write back the finished pair, else take a load
  always_comb begin
    if (s2_tag.valid && s2_tag.we) begin
      ram_we[0]    = 1'b1;
      ram_we[1]    = 1'b1;
      ram_waddr[0] = s2_tag.up_bank ? s2_tag.lo_addr : s2_tag.up_addr;
      ram_waddr[1] = s2_tag.up_bank ? s2_tag.up_addr : s2_tag.lo_addr;
      ram_wdata[0] = s2_tag.up_bank ? {new_lo_re, new_lo_im} : {new_up_re, new_up_im};
      ram_wdata[1] = s2_tag.up_bank ? {new_up_re, new_up_im} : {new_lo_re, new_lo_im};
    end else begin
      ram_we[0]    = (state == S_DECODE) && (item_mode == MODE_LOAD) && !idx_bad && !idx_bank;
      ram_we[1]    = (state == S_DECODE) && (item_mode == MODE_LOAD) && !idx_bad && idx_bank;
      ram_waddr[0] = idx_addr;
      ram_waddr[1] = idx_addr;
      ram_wdata[0] = {item_load_re, item_load_im};
      ram_wdata[1] = {item_load_re, item_load_im};
    end
  end

  ccug_ram #(
    .ADDR_BITS (BANK_ADDR_BITS),
    .DATA_BITS (ENTRY_BITS)
  ) u_bank0 (
    .clk   (clk),
    .we    (ram_we[0]),
    .waddr (ram_waddr[0]),
    .wdata (ram_wdata[0]),
    .raddr (ram_raddr[0]),
    .rdata (ram_rdata[0])
  );

  ccug_ram #(
    .ADDR_BITS (BANK_ADDR_BITS),
    .DATA_BITS (ENTRY_BITS)
  ) u_bank1 (
    .clk   (clk),
    .we    (ram_we[1]),
    .waddr (ram_waddr[1]),
    .wdata (ram_wdata[1]),
    .raddr (ram_raddr[1]),
    .rdata (ram_rdata[1])
  );

  assign up_word  = s1_tag.up_bank ? ram_rdata[1] : ram_rdata[0];
  assign lo_word  = s1_tag.up_bank ? ram_rdata[0] : ram_rdata[1];
  assign idx_word = idx_bank ? ram_rdata[1] : ram_rdata[0];

  ccug_bfly u_bfly (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (s1_tag),
    .ur      (up_word[ENTRY_BITS-1:AMP_BITS]),
    .ui      (up_word[AMP_BITS-1:0]),
    .lr      (lo_word[ENTRY_BITS-1:AMP_BITS]),
    .li      (lo_word[AMP_BITS-1:0]),
    .ar      (item_ar),
    .ai      (item_ai),
    .br      (item_br),
    .bi      (item_bi),
    .out_tag (s2_tag),
    .up_re   (new_up_re),
    .up_im   (new_up_im),
    .lo_re   (new_lo_re),
    .lo_im   (new_lo_im)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (item_mode == MODE_READ && !idx_bad) begin
          state_next = S_RDWAIT;
        end else if (item_mode == MODE_GATE && !qubit_bad) begin
          state_next = S_SWEEP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_RDWAIT: state_next = S_FINISH;
      S_SWEEP: begin
        if (pair_done) begin
          state_next = S_DRAIN;
        end
      end
      // The last pair is written back at the edge that leaves this state
      S_DRAIN: begin
        if (!s1_tag.valid) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      res_re <= '0;
      res_im <= '0;
      priority if ((item_mode == MODE_LOAD || item_mode == MODE_READ) && idx_bad) begin
        res_status <= ST_BAD_INDEX;
      end else if (item_mode == MODE_GATE && qubit_bad) begin
        res_status <= ST_BAD_QUBIT;
      end else begin
        res_status <= ST_DONE;
      end
    end else if (state == S_RDWAIT) begin
      res_re <= idx_word[ENTRY_BITS-1:AMP_BITS];
      res_im <= idx_word[AMP_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      read_re <= res_re;
      read_im <= res_im;
      status  <= res_status;
    end
  end

endmodule

// File: rtl/ccug_ram.sv
module ccug_ram #(
  parameter int ADDR_BITS = 9,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ccug_bfly.sv
module ccug_bfly
  import ccug_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  tag_t                       in_tag,
  input  logic signed [AMP_BITS-1:0] ur,
  input  logic signed [AMP_BITS-1:0] ui,
  input  logic signed [AMP_BITS-1:0] lr,
  input  logic signed [AMP_BITS-1:0] li,
  input  logic signed [AMP_BITS-1:0] ar,
  input  logic signed [AMP_BITS-1:0] ai,
  input  logic signed [AMP_BITS-1:0] br,
  input  logic signed [AMP_BITS-1:0] bi,
  output tag_t                       out_tag,
  output logic signed [AMP_BITS-1:0] up_re,
  output logic signed [AMP_BITS-1:0] up_im,
  output logic signed [AMP_BITS-1:0] lo_re,
  output logic signed [AMP_BITS-1:0] lo_im
);

  logic signed [PROD_BITS-1:0] p_ar_ur, p_ai_ui, p_br_lr, p_bi_li;
  logic signed [PROD_BITS-1:0] p_ar_ui, p_ai_ur, p_br_li, p_bi_lr;
  logic signed [PROD_BITS-1:0] p_br_ur, p_bi_ui, p_ar_lr, p_ai_li;
  logic signed [PROD_BITS-1:0] p_br_ui, p_bi_ur, p_ar_li, p_ai_lr;
  logic signed [SUM_BITS-1:0]  up_re_sum, up_im_sum, lo_re_sum, lo_im_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else begin
      out_tag <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    p_ar_ur <= ar * ur;
    p_ai_ui <= ai * ui;
    p_br_lr <= br * lr;
    p_bi_li <= bi * li;
    p_ar_ui <= ar * ui;
    p_ai_ur <= ai * ur;
    p_br_li <= br * li;
    p_bi_lr <= bi * lr;
    p_br_ur <= br * ur;
    p_bi_ui <= bi * ui;
    p_ar_lr <= ar * lr;
    p_ai_li <= ai * li;
    p_br_ui <= br * ui;
    p_bi_ur <= bi * ur;
    p_ar_li <= ar * li;
    p_ai_lr <= ai * lr;
  end

  // Round each product, sum exactly, then clamp
  always_comb begin
    up_re_sum = SUM_BITS'(rnd(p_ar_ur)) - SUM_BITS'(rnd(p_ai_ui))
              - SUM_BITS'(rnd(p_br_lr)) - SUM_BITS'(rnd(p_bi_li));
    up_im_sum = SUM_BITS'(rnd(p_ar_ui)) + SUM_BITS'(rnd(p_ai_ur))
              - SUM_BITS'(rnd(p_br_li)) + SUM_BITS'(rnd(p_bi_lr));
    lo_re_sum = SUM_BITS'(rnd(p_br_ur)) - SUM_BITS'(rnd(p_bi_ui))
              + SUM_BITS'(rnd(p_ar_lr)) + SUM_BITS'(rnd(p_ai_li));
    lo_im_sum = SUM_BITS'(rnd(p_br_ui)) + SUM_BITS'(rnd(p_bi_ur))
              + SUM_BITS'(rnd(p_ar_li)) - SUM_BITS'(rnd(p_ai_lr));
    up_re = sat(up_re_sum);
    up_im = sat(up_im_sum);
    lo_re = sat(lo_re_sum);
    lo_im = sat(lo_im_sum);
  end

endmodule

// File: rtl/ccug_checker.sv
module ccug_checker
  import ccug_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [AMP_BITS-1:0] read_re,
  input logic signed [AMP_BITS-1:0] read_im,
  input logic [STAT_BITS-1:0]       status
);

  // Nothing to deliver straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_re) && $stable(read_im)
                               && $stable(status))
    else $error("stalled result changed");

  // Amplitude fields carry data only on a completed read
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> read_re == '0 && read_im == '0)
    else $error("amplitude fields not zero on a failed item");

  // One item at a time: busy straight after an input transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

endmodule

bind controlled_compact_unitary_gate ccug_checker u_ccug_checker (.*);

// File: tb/sv/testbench.sv
module testbench;
  import ccug_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd3;
  localparam int STORE_DEPTH = 1 << MAX_QUBITS;
  localparam int QSEL_TOP = (1 << QSEL_BITS) - 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 12;
  localparam logic signed [AMP_BITS-1:0] AMP_TOP = {1'b0, {(AMP_BITS-1){1'b1}}};
  localparam logic signed [AMP_BITS-1:0] AMP_BOTTOM = {1'b1, {(AMP_BITS-1){1'b0}}};

  typedef struct {
    logic [MODE_BITS-1:0] mode;
    logic [IDX_BITS-1:0] amp_index;
    logic signed [AMP_BITS-1:0] load_re;
    logic signed [AMP_BITS-1:0] load_im;
    logic [QSEL_BITS-1:0] target_qubit;
    logic [QSEL_BITS-1:0] control_qubit;
    logic control_used;
    logic signed [AMP_BITS-1:0] alpha_re;
    logic signed [AMP_BITS-1:0] alpha_im;
    logic signed [AMP_BITS-1:0] beta_re;
    logic signed [AMP_BITS-1:0] beta_im;
  } gate_req_t;

  typedef struct {
    logic signed [AMP_BITS-1:0] re;
    logic signed [AMP_BITS-1:0] im;
    logic [STAT_BITS-1:0] status;
  } gate_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [QSEL_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_BITS-1:0] mode = '0;
  logic [IDX_BITS-1:0] amp_index = '0;
  logic signed [AMP_BITS-1:0] load_re = '0;
  logic signed [AMP_BITS-1:0] load_im = '0;
  logic [QSEL_BITS-1:0] target_qubit = '0;
  logic [QSEL_BITS-1:0] control_qubit = '0;
  logic control_used = 1'b0;
  logic signed [AMP_BITS-1:0] alpha_re = '0;
  logic signed [AMP_BITS-1:0] alpha_im = '0;
  logic signed [AMP_BITS-1:0] beta_re = '0;
  logic signed [AMP_BITS-1:0] beta_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AMP_BITS-1:0] read_re;
  logic signed [AMP_BITS-1:0] read_im;
  logic [STAT_BITS-1:0] status;

  // predictor state: state vector and qubit count register
  logic signed [AMP_BITS-1:0] sv_re [STORE_DEPTH];
  logic signed [AMP_BITS-1:0] sv_im [STORE_DEPTH];
  logic [QSEL_BITS-1:0] qubit_reg = QUBITS_RESET;

  // entries given a value so far, as seen by the stimulus
  bit loaded [STORE_DEPTH];

  gate_req_t queued_ops [$];
  gate_res_t predicted_replies [$];
  gate_req_t cur_op;
  gate_res_t want;
  gate_res_t got_pred;

  int ops_queued = 0;
  int ops_taken = 0;
  int replies_checked = 0;
  int mismatches = 0;
  int loads_seen = 0;
  int reads_seen = 0;
  int gates_seen = 0;
  int refused_seen = 0;
  int settings_used = 0;
  int gap_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  logic [QSEL_BITS-1:0] phase_regs [PHASES] = '{1, 3, 0, 5, 4, 10, 15, 12, 7, 2, 6, 1};

  controlled_compact_unitary_gate DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned qubits_in_effect(logic [QSEL_BITS-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_QUBITS) return MAX_QUBITS;
    return v;
  endfunction

  // product of two Q1.15 values rounded to Q2.15, nearest with ties up
  function automatic longint round_q(longint p);
    return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [AMP_BITS-1:0] clamp_amp(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< FRAC) - 1;
    lo = -(longint'(1) <<< FRAC);
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return AMP_BITS'(v);
  endfunction

  function automatic gate_res_t predict_gate_op(gate_req_t r);
    gate_res_t res;
    int unsigned nq, span, half, up, lo;
    longint ar, ai, br, bi, ur, ui, lr, li;
    res.re = '0;
    res.im = '0;
    res.status = ST_DONE;
    nq = qubits_in_effect(qubit_reg);
    span = 1 << nq;
    if (r.mode == MODE_LOAD || r.mode == MODE_READ) begin
      if (r.amp_index >= span) begin
        res.status = ST_BAD_INDEX;
      end else if (r.mode == MODE_LOAD) begin
        sv_re[r.amp_index] = r.load_re;
        sv_im[r.amp_index] = r.load_im;
      end else begin
        res.re = sv_re[r.amp_index];
        res.im = sv_im[r.amp_index];
      end
    end else if (r.mode == MODE_GATE) begin
      if (r.target_qubit >= nq || (r.control_used &&
          (r.control_qubit >= nq || r.control_qubit == r.target_qubit))) begin
        res.status = ST_BAD_QUBIT;
      end else begin
        ar = r.alpha_re;
        ai = r.alpha_im;
        br = r.beta_re;
        bi = r.beta_im;
        half = 1 << r.target_qubit;
        for (up = 0; up < span; up++) begin
          if ((up & half) != 0) continue;
          if (r.control_used && ((up >> r.control_qubit) & 1) == 0) continue;
          lo = up | half;
          ur = sv_re[up];
          ui = sv_im[up];
          lr = sv_re[lo];
          li = sv_im[lo];
          sv_re[up] = clamp_amp(round_q(ar * ur) - round_q(ai * ui)
                                - round_q(br * lr) - round_q(bi * li));
          sv_im[up] = clamp_amp(round_q(ar * ui) + round_q(ai * ur)
                                - round_q(br * li) + round_q(bi * lr));
          sv_re[lo] = clamp_amp(round_q(br * ur) - round_q(bi * ui)
                                + round_q(ar * lr) + round_q(ai * li));
          sv_im[lo] = clamp_amp(round_q(br * ui) + round_q(bi * ur)
                                + round_q(ar * li) - round_q(ai * lr));
        end
      end
    end
    return res;
  endfunction

  function automatic logic signed [AMP_BITS-1:0] pick_amp();
    case ($urandom_range(0, 9))
      0: return AMP_TOP;
      1: return AMP_BOTTOM;
      2: return '0;
      default: return AMP_BITS'($urandom);
    endcase
  endfunction

  function automatic gate_req_t scatter_op();
    gate_req_t r;
    r.mode = MODE_BITS'($urandom);
    r.amp_index = IDX_BITS'($urandom);
    r.load_re = pick_amp();
    r.load_im = pick_amp();
    r.target_qubit = QSEL_BITS'($urandom);
    r.control_qubit = QSEL_BITS'($urandom);
    r.control_used = 1'($urandom);
    r.alpha_re = pick_amp();
    r.alpha_im = pick_amp();
    r.beta_re = pick_amp();
    r.beta_im = pick_amp();
    return r;
  endfunction

  // random mix; every entry in use has been loaded before this is called
  function automatic gate_req_t mixed_op(int unsigned nq);
    gate_req_t r;
    int unsigned span, pick;
    r = scatter_op();
    span = 1 << nq;
    pick = $urandom_range(0, 99);
    if (pick >= 58 && pick < 66 && span == STORE_DEPTH) pick = 40;
    if (pick < 30) begin
      r.mode = MODE_LOAD;
      r.amp_index = IDX_BITS'($urandom_range(0, span - 1));
    end else if (pick < 58) begin
      r.mode = MODE_READ;
      r.amp_index = IDX_BITS'($urandom_range(0, span - 1));
    end else if (pick < 66) begin
      r.mode = ($urandom_range(0, 1) != 0) ? MODE_READ : MODE_LOAD;
      r.amp_index = IDX_BITS'($urandom_range(span, STORE_DEPTH - 1));
    end else if (pick < 92) begin
      r.mode = MODE_GATE;
      r.target_qubit = QSEL_BITS'($urandom_range(0, nq - 1));
      r.control_used = (nq > 1) && ($urandom_range(0, 1) != 0);
      if (r.control_used) begin
        r.control_qubit = QSEL_BITS'($urandom_range(0, nq - 2));
        if (r.control_qubit >= r.target_qubit) r.control_qubit++;
      end
    end else if (pick < 97) begin
      r.mode = MODE_GATE;
      r.target_qubit = QSEL_BITS'($urandom_range(0, nq - 1));
      case ($urandom_range(0, 2))
        0: r.target_qubit = QSEL_BITS'($urandom_range(nq, QSEL_TOP));
        1: begin
          r.control_used = 1'b1;
          r.control_qubit = r.target_qubit;
        end
        default: begin
          r.control_used = 1'b1;
          r.control_qubit = QSEL_BITS'($urandom_range(nq, QSEL_TOP));
        end
      endcase
    end else begin
      r.mode = MODE_NONE;
    end
    return r;
  endfunction

  task automatic queue_op(gate_req_t r, int unsigned nq);
    queued_ops.push_back(r);
    ops_queued++;
    if (r.mode == MODE_LOAD && r.amp_index < (1 << nq)) loaded[r.amp_index] = 1'b1;
  endtask

  task automatic flag_error(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (ops_taken != ops_queued || predicted_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_qubit_reg(logic [QSEL_BITS-1:0] v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    qubit_reg = v;
    settings_used++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        got_pred = predict_gate_op(cur_op);
        predicted_replies.push_back(got_pred);
        ops_taken++;
        if (got_pred.status != ST_DONE || cur_op.mode == MODE_NONE) refused_seen++;
        else if (cur_op.mode == MODE_LOAD) loads_seen++;
        else if (cur_op.mode == MODE_READ) reads_seen++;
        else gates_seen++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else if (queued_ops.size() != 0) begin
        cur_op = queued_ops.pop_front();
        mode <= cur_op.mode;
        amp_index <= cur_op.amp_index;
        load_re <= cur_op.load_re;
        load_im <= cur_op.load_im;
        target_qubit <= cur_op.target_qubit;
        control_qubit <= cur_op.control_qubit;
        control_used <= cur_op.control_used;
        alpha_re <= cur_op.alpha_re;
        alpha_im <= cur_op.alpha_im;
        beta_re <= cur_op.beta_re;
        beta_im <= cur_op.beta_im;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          flag_error("result with nothing outstanding");
        end else begin
          want = predicted_replies.pop_front();
          replies_checked++;
          if (read_re !== want.re)
            flag_error($sformatf("result %0d read_re got %0d want %0d",
                                 replies_checked, read_re, want.re));
          if (read_im !== want.im)
            flag_error($sformatf("result %0d read_im got %0d want %0d",
                                 replies_checked, read_im, want.im));
          if (status !== want.status)
            flag_error($sformatf("result %0d status got %0d want %0d",
                                 replies_checked, status, want.status));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", quiet_cycles);
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    gate_req_t op;
    int unsigned nq;
    int unsigned i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset value of the register: full store in use
    nq = qubits_in_effect(QUBITS_RESET);
    op = scatter_op();
    op.mode = MODE_LOAD; op.amp_index = IDX_BITS'(STORE_DEPTH - 1);
    op.load_re = AMP_TOP; op.load_im = AMP_BOTTOM;
    queue_op(op, nq);
    op = scatter_op();
    op.mode = MODE_READ; op.amp_index = IDX_BITS'(STORE_DEPTH - 1);
    queue_op(op, nq);
    op = scatter_op();
    op.mode = MODE_GATE; op.target_qubit = QSEL_BITS'(MAX_QUBITS); op.control_used = 1'b0;
    queue_op(op, nq);

    write_qubit_reg(2);
    nq = 2;
    for (i = 0; i < 4; i++) begin
      op = scatter_op();
      op.mode = MODE_LOAD; op.amp_index = IDX_BITS'(i);
      case (i)
        0: begin op.load_re = AMP_TOP; op.load_im = AMP_BOTTOM; end
        1: begin op.load_re = AMP_BOTTOM; op.load_im = AMP_TOP; end
        2: begin op.load_re = '0; op.load_im = '1; end
        default: begin op.load_re = 16384; op.load_im = -16384; end
      endcase
      queue_op(op, nq);
    end
    op = scatter_op(); op.mode = MODE_READ; op.amp_index = 0; queue_op(op, nq);
    op = scatter_op(); op.mode = MODE_READ; op.amp_index = 3; queue_op(op, nq);
    // index past the amplitudes in use
    op = scatter_op(); op.mode = MODE_LOAD; op.amp_index = 4; queue_op(op, nq);
    op = scatter_op(); op.mode = MODE_READ; op.amp_index = '1; queue_op(op, nq);
    // identity, then all coefficients at the negative extreme to force saturation
    op = scatter_op();
    op.mode = MODE_GATE; op.target_qubit = 0; op.control_used = 1'b0;
    op.alpha_re = AMP_TOP; op.alpha_im = '0; op.beta_re = '0; op.beta_im = '0;
    queue_op(op, nq);
    op = scatter_op();
    op.mode = MODE_GATE; op.target_qubit = 1; op.control_used = 1'b0;
    op.alpha_re = AMP_BOTTOM; op.alpha_im = AMP_BOTTOM;
    op.beta_re = AMP_BOTTOM; op.beta_im = AMP_BOTTOM;
    queue_op(op, nq);
    op = scatter_op();
    op.mode = MODE_GATE; op.target_qubit = 0; op.control_used = 1'b1; op.control_qubit = 1;
    queue_op(op, nq);
    op = scatter_op();
    op.mode = MODE_GATE; op.target_qubit = 1; op.control_used = 1'b1; op.control_qubit = 0;
    queue_op(op, nq);
    // bad target, control equal to target, control out of range
    op = scatter_op(); op.mode = MODE_GATE; op.target_qubit = 2; queue_op(op, nq);
    op = scatter_op(); op.mode = MODE_GATE; op.target_qubit = '1; queue_op(op, nq);
    op = scatter_op();
    op.mode = MODE_GATE; op.target_qubit = 0; op.control_used = 1'b1; op.control_qubit = 0;
    queue_op(op, nq);
    op = scatter_op();
    op.mode = MODE_GATE; op.target_qubit = 1; op.control_used = 1'b1; op.control_qubit = 2;
    queue_op(op, nq);
    op = scatter_op();
    op.mode = MODE_GATE; op.target_qubit = 0; op.control_used = 1'b1; op.control_qubit = '1;
    queue_op(op, nq);
    op = scatter_op(); op.mode = MODE_NONE; queue_op(op, nq);
    for (i = 0; i < 4; i++) begin
      op = scatter_op(); op.mode = MODE_READ; op.amp_index = IDX_BITS'(i); queue_op(op, nq);
    end

    foreach (phase_regs[p]) begin
      write_qubit_reg(phase_regs[p]);
      nq = qubits_in_effect(phase_regs[p]);
      // drop idling in one middle phase and in the closing phases
      idle_on = (p != 3) && (p < PHASES - 2);
      for (i = 0; i < (1 << nq); i++) begin
        if (!loaded[i]) begin
          op = scatter_op();
          op.mode = MODE_LOAD;
          op.amp_index = IDX_BITS'(i);
          queue_op(op, nq);
        end
      end
      repeat ($urandom_range(14, 22)) queue_op(mixed_op(nq), nq);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d loads, %0d reads, %0d gates applied, %0d refused or ignored items",
             loads_seen, reads_seen, gates_seen, refused_seen);
    $display("over %0d register settings; %0d results compared, %0d mismatches",
             settings_used, replies_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: controlled_compact_unitary_gate.f
rtl/ccug_pkg.sv
rtl/ccug_ram.sv
rtl/ccug_bfly.sv
rtl/controlled_compact_unitary_gate.sv
rtl/ccug_checker.sv
tb/sv/testbench.sv
